@@ sv/epmd_pkg.sv @@
`timescale 1ns / 1ps

package epmd_pkg;

    // field widths
    localparam int TARGET_W   = 20;
    localparam int COUNT_W    = 16;
    localparam int TIME_W     = 32;
    localparam int GAIN_W     = 24;
    localparam int DUTY_W     = 7;
    localparam int VEL_W      = 32;
    localparam int POS_W      = 17;
    localparam int DP_W       = 18;
    localparam int ANGLE_W    = 22;
    localparam int ERR_W      = 23;
    localparam int MUL_A_W    = 33;
    localparam int MUL_B_W    = 26;
    localparam int PROD_W     = 59;
    localparam int NUM_W      = 58;
    localparam int QUO_W      = 42;
    localparam int CNT_W      = 6;
    localparam int PC_W       = 4;
    localparam int KM_SPLIT   = 20;
    localparam int CFG_IDX_W  = 2;

    // arithmetic constants
    localparam logic [63:0] ANGLE_K  = 64'd1646900;
    localparam logic [63:0] US_PER_S = 64'd1000000;
    localparam logic [63:0] KM       = ANGLE_K * US_PER_S;
    localparam logic [63:0] KM_HI    = KM >> KM_SPLIT;
    localparam logic [63:0] KM_LO    = KM & ((64'd1 << KM_SPLIT) - 64'd1);
    localparam logic [DUTY_W-1:0] DUTY_MAX = 7'd100;
    localparam logic [CNT_W-1:0] DIV_LAST_CNT = CNT_W'(QUO_W - 1);

    // register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] REG_POSITION_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_GAIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENCODER_OFFSET = 2'd2;
    localparam logic [GAIN_W-1:0] POSITION_GAIN_RST = 24'd4172021;
    localparam logic [GAIN_W-1:0] VELOCITY_GAIN_RST = 24'd0;

    // microcode fields
    typedef enum logic [1:0] {
        A_POS,
        A_MAG,
        A_ERR,
        A_VEL
    } mul_a_t;

    typedef enum logic [2:0] {
        B_ANGLE_K,
        B_KM_HI,
        B_KM_LO,
        B_POS_GAIN,
        B_VEL_GAIN
    } mul_b_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ANGLE,
        OP_NUM_HI,
        OP_NUM_ADD,
        OP_DRIVE_LOAD,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_VEL,
        OP_DRIVE_SUB,
        OP_EMIT
    } op_t;

    typedef enum logic {
        JMP_NONE,
        JMP_DIV_LOOP
    } jump_t;

    typedef struct packed {
        mul_a_t            a_sel;
        mul_b_t            b_sel;
        logic              mul_en;
        op_t               op;
        jump_t             jmp;
        logic [PC_W-1:0]   target;
    } ctrl_t;

    typedef struct packed {
        logic [DUTY_W-1:0]       duty;
        logic                    reverse;
        logic signed [VEL_W-1:0] velocity;
    } result_t;

    localparam logic [PC_W-1:0] PC_DIV_LOOP = 4'd6;

    // control store
    function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
        ctrl_t w;
        w.a_sel  = A_POS;
        w.b_sel  = B_ANGLE_K;
        w.mul_en = 1'b0;
        w.op     = OP_NOP;
        w.jmp    = JMP_NONE;
        w.target = '0;
        unique case (pc)
            4'd0:
            begin
                w.a_sel  = A_POS;
                w.b_sel  = B_ANGLE_K;
                w.mul_en = 1'b1;
            end
            4'd1:
            begin
                w.a_sel  = A_MAG;
                w.b_sel  = B_KM_HI;
                w.mul_en = 1'b1;
                w.op     = OP_ANGLE;
            end
            4'd2:
            begin
                w.a_sel  = A_MAG;
                w.b_sel  = B_KM_LO;
                w.mul_en = 1'b1;
                w.op     = OP_NUM_HI;
            end
            4'd3:
            begin
                w.a_sel  = A_ERR;
                w.b_sel  = B_POS_GAIN;
                w.mul_en = 1'b1;
                w.op     = OP_NUM_ADD;
            end
            4'd4:
            begin
                w.op = OP_DRIVE_LOAD;
            end
            4'd5:
            begin
                w.op = OP_DIV_INIT;
            end
            4'd6:
            begin
                w.op     = OP_DIV_STEP;
                w.jmp    = JMP_DIV_LOOP;
                w.target = PC_DIV_LOOP;
            end
            4'd7:
            begin
                w.op = OP_VEL;
            end
            4'd8:
            begin
                w.a_sel  = A_VEL;
                w.b_sel  = B_VEL_GAIN;
                w.mul_en = 1'b1;
            end
            4'd9:
            begin
                w.op = OP_DRIVE_SUB;
            end
            4'd10:
            begin
                w.op = OP_EMIT;
            end
            default:
            begin
                w.op = OP_EMIT;
            end
        endcase
        return w;
    endfunction

endpackage

@@ sv/epmd_sample_if.sv @@
`timescale 1ns / 1ps

interface epmd_sample_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [epmd_pkg::TARGET_W-1:0]      target_angle;
    logic signed [epmd_pkg::COUNT_W-1:0]       encoder_count;
    logic [epmd_pkg::TIME_W-1:0]               timestamp_us;

    modport source (output valid, target_angle, encoder_count, timestamp_us, input ready);
    modport sink (input valid, target_angle, encoder_count, timestamp_us, output ready);
endinterface

@@ sv/epmd_result_if.sv @@
`timescale 1ns / 1ps

interface epmd_result_if;
    logic                                   valid;
    logic                                   ready;
    logic [epmd_pkg::DUTY_W-1:0]            drive_duty;
    logic                                   reverse_direction;
    logic signed [epmd_pkg::VEL_W-1:0]      angular_velocity;

    modport source (output valid, drive_duty, reverse_direction, angular_velocity, input ready);
    modport sink (input valid, drive_duty, reverse_direction, angular_velocity, output ready);
endinterface

@@ sv/epmd_seq.sv @@
`timescale 1ns / 1ps

module epmd_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              stall,
    input  logic              div_last,
    output logic              busy,
    output epmd_pkg::ctrl_t   ctrl
);

    logic                          busy_reg;
    logic                          busy_next;
    logic [epmd_pkg::PC_W-1:0]     pc_reg;
    logic [epmd_pkg::PC_W-1:0]     pc_next;
    epmd_pkg::ctrl_t               word;

    // control store read, inert while idle
    always_comb
    begin
        word = epmd_pkg::ucode(pc_reg);
        if (!busy_reg)
        begin
            word.mul_en = 1'b0;
            word.op     = epmd_pkg::OP_NOP;
            word.jmp    = epmd_pkg::JMP_NONE;
        end
    end

    // step counter with conditional jump
    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                pc_next   = '0;
            end
        end
        else if (!stall)
        begin
            if (word.op == epmd_pkg::OP_EMIT)
            begin
                busy_next = 1'b0;
                pc_next   = '0;
            end
            else if (word.jmp == epmd_pkg::JMP_DIV_LOOP && !div_last)
            begin
                pc_next = word.target;
            end
            else
            begin
                pc_next = pc_reg + epmd_pkg::PC_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
        end
    end

    assign busy = busy_reg;
    assign ctrl = word;

endmodule

@@ sv/epmd_datapath.sv @@
`timescale 1ns / 1ps

module epmd_datapath (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    load,
    input  logic signed [epmd_pkg::TARGET_W-1:0]    target_angle,
    input  logic signed [epmd_pkg::COUNT_W-1:0]     encoder_count,
    input  logic [epmd_pkg::TIME_W-1:0]             timestamp_us,
    input  logic [epmd_pkg::GAIN_W-1:0]             position_gain,
    input  logic [epmd_pkg::GAIN_W-1:0]             velocity_gain,
    input  logic signed [epmd_pkg::COUNT_W-1:0]     encoder_offset,
    input  epmd_pkg::ctrl_t                         ctrl,
    output logic                                    div_last,
    output epmd_pkg::result_t                       res
);

    // sample state kept between items
    logic signed [epmd_pkg::POS_W-1:0]    last_pos_reg;
    logic [epmd_pkg::TIME_W-1:0]          last_time_reg;

    // per-item working registers
    logic signed [epmd_pkg::TARGET_W-1:0] target_reg;
    logic signed [epmd_pkg::POS_W-1:0]    p_reg;
    logic [epmd_pkg::POS_W-1:0]           mag_reg;
    logic                                 neg_reg;
    logic [epmd_pkg::TIME_W-1:0]          dt_reg;
    logic signed [epmd_pkg::ERR_W-1:0]    err_reg;
    logic signed [epmd_pkg::PROD_W-1:0]   prod_reg;
    logic [epmd_pkg::NUM_W-1:0]           num_reg;
    logic [epmd_pkg::QUO_W-1:0]           quo_reg;
    logic [epmd_pkg::TIME_W-1:0]          rem_reg;
    logic [epmd_pkg::CNT_W-1:0]           cnt_reg;
    logic signed [epmd_pkg::VEL_W-1:0]    vel_reg;
    logic signed [epmd_pkg::PROD_W-1:0]   drive_reg;

    logic signed [epmd_pkg::POS_W-1:0]    p_now;
    logic signed [epmd_pkg::DP_W-1:0]     dp_now;
    logic signed [epmd_pkg::MUL_A_W-1:0]  a_op;
    logic signed [epmd_pkg::MUL_B_W-1:0]  b_op;
    logic signed [epmd_pkg::PROD_W-1:0]   prod_next;
    logic signed [37:0]                   ang_sum;
    logic signed [epmd_pkg::ANGLE_W-1:0]  angle;
    logic [epmd_pkg::TIME_W:0]            shifted;
    logic [epmd_pkg::TIME_W+1:0]          diff;
    logic signed [epmd_pkg::VEL_W-1:0]    vel_next;
    logic [epmd_pkg::PROD_W-1:0]          dmag;

    // offset position and differences at load
    assign p_now  = epmd_pkg::POS_W'(encoder_count) - epmd_pkg::POS_W'(encoder_offset);
    assign dp_now = epmd_pkg::DP_W'(p_now) - epmd_pkg::DP_W'(last_pos_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_pos_reg  <= '0;
            last_time_reg <= '0;
        end
        else if (load)
        begin
            last_pos_reg  <= p_now;
            last_time_reg <= timestamp_us;
        end
    end

    // shared multiplier operand select
    always_comb
    begin
        unique case (ctrl.a_sel)
            epmd_pkg::A_POS: a_op = epmd_pkg::MUL_A_W'(p_reg);
            epmd_pkg::A_MAG: a_op = $signed({16'b0, mag_reg});
            epmd_pkg::A_ERR: a_op = epmd_pkg::MUL_A_W'(err_reg);
            epmd_pkg::A_VEL: a_op = epmd_pkg::MUL_A_W'(vel_reg);
        endcase
    end

    always_comb
    begin
        unique case (ctrl.b_sel)
            epmd_pkg::B_ANGLE_K:  b_op = epmd_pkg::MUL_B_W'(epmd_pkg::ANGLE_K);
            epmd_pkg::B_KM_HI:    b_op = epmd_pkg::MUL_B_W'(epmd_pkg::KM_HI);
            epmd_pkg::B_KM_LO:    b_op = epmd_pkg::MUL_B_W'(epmd_pkg::KM_LO);
            epmd_pkg::B_POS_GAIN: b_op = $signed({2'b0, position_gain});
            epmd_pkg::B_VEL_GAIN: b_op = $signed({2'b0, velocity_gain});
            default:              b_op = '0;
        endcase
    end

    assign prod_next = a_op * b_op;

    // current angle: the Q.16 product rounded half up to an integer
    assign ang_sum = $signed(prod_reg[37:0]) + 38'sd32768;
    assign angle   = ang_sum[37:16];

    // one restoring division step
    assign shifted = {rem_reg, quo_reg[epmd_pkg::QUO_W-1]};
    assign diff    = {1'b0, shifted} - {2'b0, dt_reg};
    assign div_last = (cnt_reg == '0);

    // signed, saturated velocity from the quotient, zero when dt is zero
    always_comb
    begin
        if (dt_reg == '0)
        begin
            vel_next = '0;
        end
        else if (neg_reg)
        begin
            if (quo_reg > 42'h0_8000_0000)
            begin
                vel_next = 32'sh8000_0000;
            end
            else
            begin
                vel_next = $signed(32'd0 - quo_reg[31:0]);
            end
        end
        else
        begin
            if (quo_reg > 42'h0_7FFF_FFFF)
            begin
                vel_next = 32'sh7FFF_FFFF;
            end
            else
            begin
                vel_next = $signed(quo_reg[31:0]);
            end
        end
    end

    // item load and microcoded operations
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            target_reg <= target_angle;
            p_reg      <= p_now;
            neg_reg    <= dp_now[epmd_pkg::DP_W-1];
            mag_reg    <= dp_now[epmd_pkg::DP_W-1] ? epmd_pkg::POS_W'(18'sd0 - dp_now)
                                                   : dp_now[epmd_pkg::POS_W-1:0];
            dt_reg     <= timestamp_us - last_time_reg;
        end
        if (ctrl.mul_en)
        begin
            prod_reg <= prod_next;
        end
        unique case (ctrl.op)
            epmd_pkg::OP_ANGLE:
            begin
                err_reg <= epmd_pkg::ERR_W'(target_reg) - epmd_pkg::ERR_W'(angle);
            end
            epmd_pkg::OP_NUM_HI:
            begin
                num_reg <= {prod_reg[37:0], 20'b0};
            end
            epmd_pkg::OP_NUM_ADD:
            begin
                num_reg <= num_reg + {20'b0, prod_reg[37:0]};
            end
            epmd_pkg::OP_DRIVE_LOAD:
            begin
                drive_reg <= prod_reg;
            end
            epmd_pkg::OP_DIV_INIT:
            begin
                quo_reg <= num_reg[epmd_pkg::NUM_W-1:16];
                rem_reg <= '0;
                cnt_reg <= epmd_pkg::DIV_LAST_CNT;
            end
            epmd_pkg::OP_DIV_STEP:
            begin
                if (!diff[epmd_pkg::TIME_W+1])
                begin
                    rem_reg <= diff[epmd_pkg::TIME_W-1:0];
                    quo_reg <= {quo_reg[epmd_pkg::QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= shifted[epmd_pkg::TIME_W-1:0];
                    quo_reg <= {quo_reg[epmd_pkg::QUO_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - epmd_pkg::CNT_W'(1);
            end
            epmd_pkg::OP_VEL:
            begin
                vel_reg <= vel_next;
            end
            epmd_pkg::OP_DRIVE_SUB:
            begin
                drive_reg <= drive_reg - prod_reg;
            end
            default:
            begin
            end
        endcase
    end

    // drive to duty and direction
    assign dmag = drive_reg[epmd_pkg::PROD_W-1] ? epmd_pkg::PROD_W'(0) - drive_reg
                                                : drive_reg;

    always_comb
    begin
        if (dmag > (epmd_pkg::PROD_W'(epmd_pkg::DUTY_MAX) << 32))
        begin
            res.duty = epmd_pkg::DUTY_MAX;
        end
        else
        begin
            res.duty = dmag[38:32];
        end
        res.reverse  = drive_reg[epmd_pkg::PROD_W-1] | (drive_reg == '0);
        res.velocity = vel_reg;
    end

endmodule

@@ sv/encoder_pd_motor_drive.sv @@
// an accepted sample runs the microcode program, whose emit step loads the result
// register; emit waits while that register is still held by a stalled sink
// a new sample is taken only once the last one has been emitted; the 42-step
// restoring divider for the velocity quotient dominates; all steps share one multiplier
// reset: rst_n is asynchronous, active low; gains and offset return to their
// defaults and the stored position and timestamp return to zero
`timescale 1ns / 1ps

module encoder_pd_motor_drive (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      cfg_we,
    input  logic [epmd_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  logic [epmd_pkg::GAIN_W-1:0]               cfg_data,
    epmd_sample_if.sink                               sample,
    epmd_result_if.source                             result
);

    logic [epmd_pkg::GAIN_W-1:0]            pos_gain_reg;
    logic [epmd_pkg::GAIN_W-1:0]            vel_gain_reg;
    logic signed [epmd_pkg::COUNT_W-1:0]    offset_reg;
    logic                                   out_valid_reg;
    epmd_pkg::result_t                      out_reg;

    logic                                   busy;
    logic                                   accept;
    logic                                   emit;
    logic                                   stall;
    logic                                   emit_fire;
    logic                                   div_last;
    epmd_pkg::ctrl_t                        ctrl;
    epmd_pkg::result_t                      res;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_gain_reg <= epmd_pkg::POSITION_GAIN_RST;
            vel_gain_reg <= epmd_pkg::VELOCITY_GAIN_RST;
            offset_reg   <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == epmd_pkg::REG_POSITION_GAIN)
            begin
                pos_gain_reg <= cfg_data;
            end
            else if (cfg_index == epmd_pkg::REG_VELOCITY_GAIN)
            begin
                vel_gain_reg <= cfg_data;
            end
            else if (cfg_index == epmd_pkg::REG_ENCODER_OFFSET)
            begin
                offset_reg <= $signed(cfg_data[epmd_pkg::COUNT_W-1:0]);
            end
        end
    end

    // handshake
    assign sample.ready = !busy;
    assign accept       = sample.valid && !busy;
    assign emit         = (ctrl.op == epmd_pkg::OP_EMIT);
    assign stall        = emit && out_valid_reg && !result.ready;
    assign emit_fire    = emit && !stall;

    epmd_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .stall    (stall),
        .div_last (div_last),
        .busy     (busy),
        .ctrl     (ctrl)
    );

    epmd_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (accept),
        .target_angle   (sample.target_angle),
        .encoder_count  (sample.encoder_count),
        .timestamp_us   (sample.timestamp_us),
        .position_gain  (pos_gain_reg),
        .velocity_gain  (vel_gain_reg),
        .encoder_offset (offset_reg),
        .ctrl           (ctrl),
        .div_last       (div_last),
        .res            (res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            out_reg <= res;
        end
    end

    assign result.valid             = out_valid_reg;
    assign result.drive_duty        = out_reg.duty;
    assign result.reverse_direction = out_reg.reverse;
    assign result.angular_velocity  = out_reg.velocity;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted beat did not start the program");

    a_result_from_program: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(busy))
        else $error("result beat appeared without a running program");

    a_duty_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.drive_duty <= epmd_pkg::DUTY_MAX))
        else $error("duty above clamp");

    a_emit_ends: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire |=> !busy)
        else $error("program still busy after result");
`endif

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    typedef longint unsigned u64_t;

    localparam int TGT_MAX = 524287;
    localparam int TGT_MIN = -524288;
    localparam int CNT_MAX = 32767;
    localparam int CNT_MIN = -32768;
    localparam logic [epmd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam longint RAD_PER_COUNT = longint'(epmd_pkg::ANGLE_K);

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [epmd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [epmd_pkg::GAIN_W-1:0] cfg_data;

    epmd_sample_if sample_ch ();
    epmd_result_if result_ch ();

    encoder_pd_motor_drive DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample_ch),
        .result    (result_ch)
    );

    // controller copy: registers and stored sample
    logic [epmd_pkg::GAIN_W-1:0] kp_gain;
    logic [epmd_pkg::GAIN_W-1:0] kd_gain;
    logic signed [epmd_pkg::COUNT_W-1:0] zero_offset;
    logic signed [epmd_pkg::POS_W-1:0] prev_pos;
    logic [epmd_pkg::TIME_W-1:0] prev_ts;

    epmd_pkg::result_t pending_drive[$];
    bit failed;
    int unsigned gap_pct;
    int unsigned stall_pct;

    // pd law on one sample, advancing the stored position and time
    function automatic epmd_pkg::result_t pd_predict(
        input logic signed [epmd_pkg::TARGET_W-1:0] tgt,
        input logic signed [epmd_pkg::COUNT_W-1:0] cnt,
        input logic [epmd_pkg::TIME_W-1:0] now);
        longint pos;
        longint ang;
        longint err;
        longint dp;
        longint vel;
        longint drv;
        u64_t mag;
        u64_t quo;
        u64_t dmag;
        logic [epmd_pkg::TIME_W-1:0] dt;
        epmd_pkg::result_t want;
        pos = longint'(cnt) - longint'(zero_offset);
        ang = (pos * RAD_PER_COUNT + 32768) >>> 16;
        err = longint'(tgt) - ang;
        dp = pos - longint'(prev_pos);
        dt = now - prev_ts;
        vel = 0;
        if (dt != '0)
        begin
            mag = (dp < 0) ? u64_t'(-dp) : u64_t'(dp);
            quo = (mag * epmd_pkg::ANGLE_K * epmd_pkg::US_PER_S) / (u64_t'(dt) << 16);
            if (dp < 0)
            begin
                if (quo > 64'h8000_0000)
                    quo = 64'h8000_0000;
                vel = -longint'(quo);
            end
            else
            begin
                if (quo > 64'h7FFF_FFFF)
                    quo = 64'h7FFF_FFFF;
                vel = longint'(quo);
            end
        end
        drv = longint'(kp_gain) * err - longint'(kd_gain) * vel;
        dmag = (drv < 0) ? u64_t'(-drv) : u64_t'(drv);
        want.duty = (dmag > (u64_t'(epmd_pkg::DUTY_MAX) << 32)) ? epmd_pkg::DUTY_MAX
                                                                : epmd_pkg::DUTY_W'(dmag >> 32);
        want.reverse = (drv > 0) ? 1'b0 : 1'b1;
        want.velocity = vel[epmd_pkg::VEL_W-1:0];
        prev_pos = pos[epmd_pkg::POS_W-1:0];
        prev_ts = now;
        return want;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int unsigned idle_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 60);
        return $urandom_range(1, 3);
    endfunction

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #(15_000_000);
        $display("tb_top failed");
        $finish;
    end

    // result back-pressure
    initial
    begin
        int unsigned hold;
        hold = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                hold--;
                result_ch.ready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < stall_pct)
            begin
                hold = idle_len() - 1;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // predict on accepted samples, check every result beat
    initial
    begin
        epmd_pkg::result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (result_ch.valid && result_ch.ready)
                begin
                    if (pending_drive.size() == 0)
                    begin
                        $error("result beat with no sample waiting for it");
                        failed = 1'b1;
                    end
                    else
                    begin
                        want = pending_drive.pop_front();
                        if (result_ch.drive_duty !== want.duty)
                        begin
                            $error("drive_duty: expected %0d, got %0d",
                                   want.duty, result_ch.drive_duty);
                            failed = 1'b1;
                        end
                        if (result_ch.reverse_direction !== want.reverse)
                        begin
                            $error("reverse_direction: expected %0d, got %0d",
                                   want.reverse, result_ch.reverse_direction);
                            failed = 1'b1;
                        end
                        if (result_ch.angular_velocity !== want.velocity)
                        begin
                            $error("angular_velocity: expected %0d, got %0d",
                                   want.velocity, result_ch.angular_velocity);
                            failed = 1'b1;
                        end
                    end
                end
                if (sample_ch.valid && sample_ch.ready)
                    pending_drive.push_back(pd_predict(sample_ch.target_angle,
                                                       sample_ch.encoder_count,
                                                       sample_ch.timestamp_us));
            end
        end
    end

    // one sample beat, after an optional gap
    task automatic send_sample(input int tgt,
                               input int cnt,
                               input logic [epmd_pkg::TIME_W-1:0] ts);
        int unsigned gap;
        gap = ($urandom_range(0, 99) < gap_pct) ? idle_len() : 0;
        repeat (gap)
        begin
            @(negedge clk);
            sample_ch.valid <= 1'b0;
        end
        @(negedge clk);
        sample_ch.valid <= 1'b1;
        sample_ch.target_angle <= epmd_pkg::TARGET_W'(tgt);
        sample_ch.encoder_count <= epmd_pkg::COUNT_W'(cnt);
        sample_ch.timestamp_us <= ts;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
    endtask

    // drop valid and let every outstanding result drain
    task automatic wait_idle();
        @(negedge clk);
        sample_ch.valid <= 1'b0;
        while (pending_drive.size() != 0)
            @(posedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(input logic [epmd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [epmd_pkg::GAIN_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            epmd_pkg::REG_POSITION_GAIN:  kp_gain = value;
            epmd_pkg::REG_VELOCITY_GAIN:  kd_gain = value;
            epmd_pkg::REG_ENCODER_OFFSET: zero_offset = value[epmd_pkg::COUNT_W-1:0];
            default: ;
        endcase
    endtask

    // first sample from reset state, exact zero drive and its neighbours
    task automatic test_reset_and_zero_drive();
        send_sample(0, 0, 0);
        send_sample(3, 0, 0);
        send_sample(-3, 0, 0);
        send_sample(65536, 0, 32'd1000);
    endtask

    // field extremes, timestamp wrap, velocity saturation both ways, zero dt
    task automatic test_field_extremes();
        send_sample(TGT_MAX, CNT_MAX, 32'hFFFF_FFFF);
        send_sample(TGT_MIN, CNT_MIN, 32'd5);
        send_sample(0, CNT_MAX, 32'd6);
        send_sample(TGT_MAX, CNT_MIN, 32'd6);
        send_sample(TGT_MIN, CNT_MAX, 32'h8000_0000);
    endtask

    // register extremes, ignored index, offset upper bits ignored
    task automatic test_register_extremes();
        wait_idle();
        write_reg(REG_UNUSED, epmd_pkg::GAIN_W'($urandom));
        write_reg(epmd_pkg::REG_POSITION_GAIN, '0);
        write_reg(epmd_pkg::REG_VELOCITY_GAIN, '1);
        write_reg(epmd_pkg::REG_ENCODER_OFFSET, epmd_pkg::GAIN_W'(CNT_MIN));
        send_sample(0, CNT_MIN, 32'd100);
        send_sample(0, CNT_MIN + 1, 32'd101);
        send_sample(0, CNT_MIN, 32'd2101);
        send_sample(TGT_MAX, CNT_MIN, 32'd2101);
        wait_idle();
        write_reg(epmd_pkg::REG_POSITION_GAIN, '1);
        write_reg(epmd_pkg::REG_VELOCITY_GAIN, '0);
        write_reg(epmd_pkg::REG_ENCODER_OFFSET, {8'hA5, 16'h7FFF});
        send_sample(TGT_MAX, CNT_MIN, 32'd3000);
        send_sample(TGT_MIN, CNT_MAX, 32'd4000);
        send_sample(0, CNT_MAX, 32'd5000);
        wait_idle();
        write_reg(epmd_pkg::REG_POSITION_GAIN, epmd_pkg::POSITION_GAIN_RST);
        write_reg(epmd_pkg::REG_VELOCITY_GAIN, 24'h010000);
        write_reg(epmd_pkg::REG_ENCODER_OFFSET, '0);
        send_sample(1000, 40, 32'd6000);
        send_sample(2000, 80, 32'd7000);
        send_sample(-5000, 20, 32'd7500);
        send_sample(0, 20, 32'd7500);
    endtask

    // random settings, then mostly smooth motion with some noise
    task automatic test_random_phase(input int unsigned items, input int unsigned idle_pct,
                                     input bit near_wrap);
        logic [epmd_pkg::GAIN_W-1:0] kp;
        logic [epmd_pkg::GAIN_W-1:0] kd;
        logic [epmd_pkg::COUNT_W-1:0] ofs;
        logic [epmd_pkg::TIME_W-1:0] walk_ts;
        logic signed [epmd_pkg::TARGET_W-1:0] tgt;
        logic signed [epmd_pkg::COUNT_W-1:0] cnt;
        int walk_count;
        int nc;
        int nt;
        int unsigned pick;
        wait_idle();
        case ($urandom_range(0, 4))
            0:       kp = '0;
            1:       kp = '1;
            2:       kp = epmd_pkg::POSITION_GAIN_RST;
            3:       kp = epmd_pkg::GAIN_W'($urandom_range(0, 24'h7FFFFF));
            default: kp = epmd_pkg::GAIN_W'($urandom);
        endcase
        case ($urandom_range(0, 4))
            0:       kd = '0;
            1:       kd = '1;
            2:       kd = epmd_pkg::GAIN_W'($urandom_range(0, 24'h03FFFF));
            3:       kd = epmd_pkg::GAIN_W'($urandom_range(0, 24'h00FFFF));
            default: kd = epmd_pkg::GAIN_W'($urandom);
        endcase
        case ($urandom_range(0, 3))
            0:       ofs = 16'h8000;
            1:       ofs = 16'h7FFF;
            2:       ofs = '0;
            default: ofs = epmd_pkg::COUNT_W'($urandom);
        endcase
        if ($urandom_range(0, 2) == 0)
            write_reg(REG_UNUSED, epmd_pkg::GAIN_W'($urandom));
        write_reg(epmd_pkg::REG_POSITION_GAIN, kp);
        write_reg(epmd_pkg::REG_VELOCITY_GAIN, kd);
        write_reg(epmd_pkg::REG_ENCODER_OFFSET, {8'($urandom), ofs});
        gap_pct = idle_pct;
        stall_pct = idle_pct;
        walk_ts = near_wrap ? (32'hFFFF_FFFF - $urandom_range(0, 200000)) : $urandom;
        walk_count = int'($urandom_range(0, 20000)) - 10000;
        for (int i = 0; i < items; i++)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                nc = walk_count + int'($urandom_range(0, 80)) - 40;
                if (nc > CNT_MAX)
                    nc = CNT_MAX;
                if (nc < CNT_MIN)
                    nc = CNT_MIN;
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    walk_ts = walk_ts;
                else if (pick == 1)
                    walk_ts = walk_ts + $urandom;
                else
                    walk_ts = walk_ts + $urandom_range(100, 3000);
                if ($urandom_range(0, 3) == 0)
                    tgt = epmd_pkg::TARGET_W'($urandom);
                else
                begin
                    nt = nc * 25 + int'($urandom_range(0, 40000)) - 20000;
                    if (nt > TGT_MAX)
                        nt = TGT_MAX;
                    if (nt < TGT_MIN)
                        nt = TGT_MIN;
                    tgt = epmd_pkg::TARGET_W'(nt);
                end
                cnt = epmd_pkg::COUNT_W'(nc);
            end
            else
            begin
                tgt = epmd_pkg::TARGET_W'($urandom);
                cnt = epmd_pkg::COUNT_W'($urandom);
                walk_ts = $urandom;
            end
            walk_count = int'(cnt);
            send_sample(int'(tgt), int'(cnt), walk_ts);
        end
    endtask

    // stimulus sequence
    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sample_ch.valid = 1'b0;
        sample_ch.target_angle = '0;
        sample_ch.encoder_count = '0;
        sample_ch.timestamp_us = '0;
        kp_gain = epmd_pkg::POSITION_GAIN_RST;
        kd_gain = epmd_pkg::VELOCITY_GAIN_RST;
        zero_offset = '0;
        prev_pos = '0;
        prev_ts = '0;
        failed = 1'b0;
        gap_pct = 30;
        stall_pct = 30;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_and_zero_drive();
        test_field_extremes();
        test_register_extremes();
        test_random_phase(325, 40, 1'b0);
        test_random_phase(325, 0, 1'b1);
        test_random_phase(325, 50, 1'b0);
        test_random_phase(325, 20, 1'b1);
        test_random_phase(325, 40, 1'b0);
        test_random_phase(325, 10, 1'b0);

        // drain and allow for any stray beat
        wait_idle();
        repeat (60) @(posedge clk);
        if (!failed)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
